/* rtl/assert_macros.svh */
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fpid_pkg.sv */
package fpid_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int ONE_Q16 = 65536;

    localparam int WINDUP_LIMIT_DEF = 65536;
    localparam int INC_SLOPE_DEF    = 6554;
    localparam int DEC_SLOPE_DEF    = 6554;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_RANGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INCREASE_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INCREASE_RANGE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECREASE_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DECREASE_RANGE = 3'd7;

    // Divider request: quotient = num*65536/den, for 0 < num < den
    typedef struct packed {
        logic        start;
        logic [33:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quot;
    } div_rsp_t;

endpackage

/* rtl/fpid_div.sv */
// Restoring divider, one quotient bit per cycle, 16 quotient bits in a 17-bit result.
// Caller guarantees num < den so the result stays below one, except
// saturated cases which the caller handles itself.
module fpid_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpid_pkg::div_req_t req,
    output fpid_pkg::div_rsp_t rsp
);
    import fpid_pkg::*;

    logic [33:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [16:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] trial;

    // Shift-subtract step
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, 1'b0} - {3'b0, den_reg};
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[34])
            begin
                rem_next  = trial[33:0];
                quot_next = {quot_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[32:0], 1'b0};
                quot_next = {quot_reg[15:0], 1'b0};
            end
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* rtl/fuzzy_pid_axis_controller_top.sv */
// One axis of a fuzzy PID controller. A (measured, target) word is taken when
// in_valid is high and in_stall low. in_stall stays high from the cycle after
// the accept until the force word has moved into the output register. A
// sequencer works out fourteen memberships one at a time. A clamped membership
// is set directly, without the divider. Any other membership runs through one
// shared restoring divider, and at most seven per word need it. Then one shared
// 32x18 multiplier forms the rule products and the weighted sum. If the previous
// force word is still stalled at that point, the block waits for it. A range
// register holding zero acts as one LSB. Write the configuration through
// cfg_wr, cfg_idx and cfg_data only while no word is in flight.
module fuzzy_pid_axis_controller_top
#(
    parameter int WINDUP_LIMIT = fpid_pkg::WINDUP_LIMIT_DEF,
    parameter int INC_SLOPE    = fpid_pkg::INC_SLOPE_DEF,
    parameter int DEC_SLOPE    = fpid_pkg::DEC_SLOPE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [fpid_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [fpid_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            measured,
    input  logic signed [31:0]            target,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            force_res
);
    import fpid_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_WAIT = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // Configuration registers
    logic [CFG_W-1:0] gain_reg [4];
    logic [CFG_W-1:0] range_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                gain_reg[k]  <= '0;
                range_reg[k] <= CFG_W'(ONE_Q16);
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ERROR_GAIN:     gain_reg[0]  <= cfg_data;
                REG_ERROR_RANGE:    range_reg[0] <= cfg_data;
                REG_INTEGRAL_GAIN:  gain_reg[1]  <= cfg_data;
                REG_INTEGRAL_RANGE: range_reg[1] <= cfg_data;
                REG_INCREASE_GAIN:  gain_reg[2]  <= cfg_data;
                REG_INCREASE_RANGE: range_reg[2] <= cfg_data;
                REG_DECREASE_GAIN:  gain_reg[3]  <= cfg_data;
                REG_DECREASE_RANGE: range_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t            state_reg, state_next;
    logic signed [31:0] prev_reg, integ_reg;
    logic signed [32:0] err_reg;
    logic signed [33:0] der_reg;
    logic signed [33:0] ival_reg;
    logic [3:0]        mi_reg;          // membership index 0..13
    logic [16:0]       mem_reg [14];    // membership values
    logic [3:0]        pi_reg;          // multiplier step 0..10
    logic [16:0]       s1 [4];
    logic [16:0]       ma_reg, mb_reg;
    logic signed [49:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic signed [31:0] force_reg;
    logic              out_valid_reg;
    logic              out_free;

    // Membership request per index: value v and peak p, kind inverse
    logic signed [33:0] mv;
    logic [31:0]        mp;
    logic               minv;
    function automatic logic [31:0] peak(input logic [CFG_W-1:0] r);
        peak = (r == '0) ? 32'd1 : {1'b0, r};
    endfunction

    // Ranges 0..7 from registers, then integral and derivative ramps
    always_comb
    begin
        mv = '0; mp = 32'd1; minv = 1'b0;
        case (mi_reg)
            4'd0:  begin mv = 34'(err_reg);  mp = peak(range_reg[0]); end
            4'd1:  begin mv = -34'(err_reg); mp = peak(range_reg[0]); end
            4'd2:  begin mv = 34'(err_reg);  mp = peak(range_reg[1]); end
            4'd3:  begin mv = -34'(err_reg); mp = peak(range_reg[1]); end
            4'd4:  begin mv = 34'(err_reg);  mp = peak(range_reg[2]); end
            4'd5:  begin mv = -34'(err_reg); mp = peak(range_reg[2]); end
            4'd6:  begin mv = 34'(err_reg);  mp = peak(range_reg[3]); minv = 1'b1; end
            4'd7:  begin mv = -34'(err_reg); mp = peak(range_reg[3]); minv = 1'b1; end
            4'd8:  begin mv = ival_reg;      mp = 32'(WINDUP_LIMIT); end
            4'd9:  begin mv = -ival_reg;     mp = 32'(WINDUP_LIMIT); end
            4'd10: begin mv = der_reg;       mp = 32'(INC_SLOPE); end
            4'd11: begin mv = -der_reg;      mp = 32'(INC_SLOPE); end
            4'd12: begin mv = -der_reg;      mp = 32'(DEC_SLOPE); end
            default: begin mv = der_reg;     mp = 32'(DEC_SLOPE); end
        endcase
    end

    // Divider
    div_req_t dreq;
    div_rsp_t drsp;
    fpid_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic trivial;
    logic [16:0] trivial_val;
    always_comb
    begin
        trivial = 1'b1;
        trivial_val = '0;
        dreq = '0;
        if (!minv)
        begin
            if (mv <= 0) trivial_val = '0;
            else if (mv >= $signed({2'b0, mp})) trivial_val = 17'(ONE_Q16);
            else
            begin
                trivial = 1'b0;
                dreq.num = mv;
            end
        end
        else
        begin
            if (mv < 0 || mv >= $signed({2'b0, mp})) trivial_val = '0;
            else if (mv == 0) trivial_val = 17'(ONE_Q16);
            else
            begin
                trivial = 1'b0;
                dreq.num = 34'($signed({2'b0, mp}) - mv);
            end
        end
        dreq.den   = mp;
        dreq.start = (state_reg == ST_DIV) && !trivial;
    end

    // Rule differences in signed Q1.16
    logic signed [17:0] dif [4];
    always_comb
    begin
        dif[0] = $signed({1'b0, mem_reg[0]}) - $signed({1'b0, mem_reg[1]});
        dif[1] = $signed({1'b0, s1[0]}) - $signed({1'b0, s1[1]});
        dif[2] = $signed({1'b0, s1[2]}) - $signed({1'b0, s1[3]});
        dif[3] = $signed({1'b0, ma_reg}) - $signed({1'b0, mb_reg});
    end

    // Shared multiplier operands: steps 0..5 pair products, 6..9 gain times difference
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (pi_reg)
            4'd0: begin mul_a = 32'(mem_reg[2]); mul_b = 18'(mem_reg[8]);  end
            4'd1: begin mul_a = 32'(mem_reg[3]); mul_b = 18'(mem_reg[9]);  end
            4'd2: begin mul_a = 32'(mem_reg[4]); mul_b = 18'(mem_reg[10]); end
            4'd3: begin mul_a = 32'(mem_reg[5]); mul_b = 18'(mem_reg[11]); end
            4'd4: begin mul_a = 32'(mem_reg[6]); mul_b = 18'(mem_reg[12]); end
            4'd5: begin mul_a = 32'(mem_reg[7]); mul_b = 18'(mem_reg[13]); end
            4'd6: begin mul_a = $signed({1'b0, gain_reg[0]}); mul_b = dif[0]; end
            4'd7: begin mul_a = $signed({1'b0, gain_reg[1]}); mul_b = dif[1]; end
            4'd8: begin mul_a = $signed({1'b0, gain_reg[2]}); mul_b = dif[2]; end
            4'd9: begin mul_a = $signed({1'b0, gain_reg[3]}); mul_b = dif[3]; end
            default: ;
        endcase
    end

    // Sequencer
    logic signed [31:0] e_sat;
    logic signed [32:0] e_raw;
    logic signed [33:0] i_raw;
    logic signed [50:0] fl;
    logic signed [31:0] frc;
    assign e_raw = 33'(target) - 33'(measured);
    assign e_sat = (e_raw > 33'sd2147483647) ? 32'sh7fffffff :
                   (e_raw < -33'sd2147483648) ? 32'sh80000000 : e_raw[31:0];
    assign i_raw = 34'(integ_reg) + 34'(e_sat);

    always_comb
    begin
        fl  = 51'(acc_reg >>> 16);
        frc = (fl > 51'sd2147483647) ? 32'sh7fffffff :
              (fl < -51'sd2147483648) ? 32'sh80000000 : fl[31:0];
    end

    // Output register can take a new word
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  state_next = trivial ? ((mi_reg == 4'd13) ? ST_MUL : ST_DIV) : ST_WAIT;
            ST_WAIT: if (drsp.done) state_next = (mi_reg == 4'd13) ? ST_MUL : ST_DIV;
            ST_MUL:  if (pi_reg == 4'd10) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
            mi_reg        <= '0;
            pi_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        prev_reg <= e_sat;
                        integ_reg <= (i_raw > 34'(WINDUP_LIMIT)) ? 32'(WINDUP_LIMIT) :
                                     (i_raw < -34'(WINDUP_LIMIT)) ? -32'(WINDUP_LIMIT) :
                                     i_raw[31:0];
                        mi_reg <= '0;
                        pi_reg <= '0;
                    end
                end
                ST_DIV:  if (trivial) mi_reg <= mi_reg + 4'd1;
                ST_WAIT: if (drsp.done) mi_reg <= mi_reg + 4'd1;
                ST_MUL:  pi_reg <= pi_reg + 4'd1;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            err_reg  <= 33'(e_sat);
            der_reg  <= 34'(e_sat) - 34'(prev_reg);
            ival_reg <= (i_raw > 34'(WINDUP_LIMIT)) ? 34'(WINDUP_LIMIT) :
                        (i_raw < -34'(WINDUP_LIMIT)) ? -34'(WINDUP_LIMIT) : i_raw;
            acc_reg  <= '0;
        end
        if (state_reg == ST_DIV && trivial) mem_reg[mi_reg] <= trivial_val;
        if (state_reg == ST_WAIT && drsp.done) mem_reg[mi_reg] <= drsp.quot;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_a * mul_b;
            // pair products are taken from the registered product, then the weighted sum
            case (pi_reg) inside
                4'd1: s1[0] <= prod_reg[32:16];
                4'd2: s1[1] <= prod_reg[32:16];
                4'd3: s1[2] <= prod_reg[32:16];
                4'd4: s1[3] <= prod_reg[32:16];
                4'd5: ma_reg <= prod_reg[32:16];
                4'd6: mb_reg <= prod_reg[32:16];
                [4'd7:4'd9]: acc_reg <= acc_reg + 67'(prod_reg);
                4'd10: acc_reg <= acc_reg - 67'(prod_reg);
                default: ;
            endcase
        end
        if (state_reg == ST_OUT && out_free) force_reg <= frc;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign force_res = force_reg;

endmodule

/* rtl/fpid_checker.sv */
module fpid_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [31:0] force_res
);
`include "assert_macros.svh"

    // A word taken makes the block busy next cycle
    `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")
    // Stalled output holds
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(force_res), "output dropped")
    // A presented force word is fully known
    `ASSERT_IMPL(a_known, clk, rst_n, out_valid, !$isunknown(force_res), "unknown force word")

endmodule

bind fuzzy_pid_axis_controller_top fpid_checker u_chk (.*);

/* tb/sv/tb.sv */
module tb;
    import fpid_pkg::*;

    localparam int W_LIM   = WINDUP_LIMIT_DEF;
    localparam int INC_SLP = INC_SLOPE_DEF;
    localparam int DEC_SLP = DEC_SLOPE_DEF;
    localparam int N_PHASE = 9;
    localparam int PHASE_WORDS = 100;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] measured = '0;
    logic signed [31:0] target = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [31:0] force_res;

    fuzzy_pid_axis_controller_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr(cfg_wr), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .measured(measured), .target(target),
        .out_valid(out_valid), .out_stall(out_stall),
        .force_res(force_res)
    );

    always #5 clk = ~clk;

    // Shadow of the registers and of the controller state
    logic [CFG_W-1:0] gain_range_regs [8];
    int prev_err;
    int integ_acc;

    // Expected force words, oldest first
    logic signed [31:0] force_q [$];
    int mismatches = 0;
    int words_sent = 0;
    int words_seen = 0;
    bit idle_on = 1'b0;
    longint cycles = 0;

    // Directed words: extremes of error, integral and derivative
    typedef struct {
        logic signed [31:0] meas;
        logic signed [31:0] targ;
        bit                 typed;
        logic signed [31:0] force_val;
    } dir_row_t;

    dir_row_t dir_rows [] = '{
        '{32'sh0000_0000, 32'sh0000_0000, 1, 32'sh0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 1, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 32'sh0},
        '{32'sh8000_0000, 32'sh8000_0000, 1, 32'sh0},
        '{32'sh0000_0000, 32'sh0001_0000, 0, 32'sh0},
        '{32'sh0000_0000, 32'sh0001_0000, 0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_8000, 0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_0001, 0, 32'sh0},
        '{32'sh0000_0000, 32'shFFFF_FFFF, 0, 32'sh0},
        '{32'sh0000_0000, 32'shFFFF_0000, 0, 32'sh0},
        '{32'sh0000_0000, 32'shFFFE_0000, 0, 32'sh0},
        '{32'sh0000_199A, 32'sh0000_0000, 0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_199A, 0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_3334, 0, 32'sh0},
        '{32'sh1234_5678, 32'sh1234_5678, 0, 32'sh0},
        '{32'shFFFF_FFFF, 32'sh0000_0000, 0, 32'sh0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 0, 32'sh0},
        '{32'shAAAA_AAAA, 32'sh5555_5555, 0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_0000, 0, 32'sh0}
    };

    // Clamped ramp membership: 0 at or below zero, one at or beyond the peak
    function automatic longint ramp_memb(longint v, longint p);
        if (v <= 0) return 0;
        if (v >= p) return ONE_Q16;
        return (v * ONE_Q16) / p;
    endfunction

    // Falling membership: one at zero, 0 at and beyond the peak
    function automatic longint fall_memb(longint v, longint p);
        if (v < 0 || v >= p) return 0;
        return ((p - v) * ONE_Q16) / p;
    endfunction

    function automatic longint peak_of_reg(logic [CFG_W-1:0] r);
        return (r == 0) ? 1 : longint'(r);
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Next force word; advances the error history and the windup-clamped integral
    function automatic logic signed [31:0] next_force(logic signed [31:0] meas,
                                                      logic signed [31:0] targ);
        longint e, d, integ, er, ir, cr, dr, m_err, m_int, m_inc, m_dec, acc;
        e = sat_word(longint'(targ) - longint'(meas));
        d = e - longint'(prev_err);
        integ = longint'(integ_acc) + e;
        if (integ > W_LIM) integ = W_LIM;
        if (integ < -W_LIM) integ = -W_LIM;
        integ_acc = int'(integ);
        prev_err = int'(e);
        er = peak_of_reg(gain_range_regs[REG_ERROR_RANGE]);
        ir = peak_of_reg(gain_range_regs[REG_INTEGRAL_RANGE]);
        cr = peak_of_reg(gain_range_regs[REG_INCREASE_RANGE]);
        dr = peak_of_reg(gain_range_regs[REG_DECREASE_RANGE]);
        m_err = ramp_memb(e, er) - ramp_memb(-e, er);
        m_int = (ramp_memb(e, ir) * ramp_memb(integ, W_LIM)) / ONE_Q16
              - (ramp_memb(-e, ir) * ramp_memb(-integ, W_LIM)) / ONE_Q16;
        m_inc = (ramp_memb(e, cr) * ramp_memb(d, INC_SLP)) / ONE_Q16
              - (ramp_memb(-e, cr) * ramp_memb(-d, INC_SLP)) / ONE_Q16;
        m_dec = (fall_memb(e, dr) * ramp_memb(-d, DEC_SLP)) / ONE_Q16
              - (fall_memb(-e, dr) * ramp_memb(d, DEC_SLP)) / ONE_Q16;
        acc = longint'(gain_range_regs[REG_ERROR_GAIN]) * m_err
            + longint'(gain_range_regs[REG_INTEGRAL_GAIN]) * m_int
            + longint'(gain_range_regs[REG_INCREASE_GAIN]) * m_inc
            - longint'(gain_range_regs[REG_DECREASE_GAIN]) * m_dec;
        return 32'(sat_word(acc >>> 16));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        gain_range_regs[idx] = val;
        @(posedge clk);
    endtask

    task automatic load_gains(logic [CFG_W-1:0] eg, logic [CFG_W-1:0] er,
                              logic [CFG_W-1:0] ig, logic [CFG_W-1:0] ir,
                              logic [CFG_W-1:0] cg, logic [CFG_W-1:0] cr,
                              logic [CFG_W-1:0] dg, logic [CFG_W-1:0] dr);
        write_reg(REG_ERROR_GAIN, eg);
        write_reg(REG_ERROR_RANGE, er);
        write_reg(REG_INTEGRAL_GAIN, ig);
        write_reg(REG_INTEGRAL_RANGE, ir);
        write_reg(REG_INCREASE_GAIN, cg);
        write_reg(REG_INCREASE_RANGE, cr);
        write_reg(REG_DECREASE_GAIN, dg);
        write_reg(REG_DECREASE_RANGE, dr);
        cfg_wr <= 1'b0;
        @(posedge clk);
    endtask

    // Random register value, mostly scaled down so memberships land mid-ramp
    function automatic logic [CFG_W-1:0] rand_reg();
        logic [CFG_W-1:0] v;
        v = CFG_W'($urandom) >> $urandom_range(0, 30);
        if ($urandom_range(0, 15) == 0) v = '0;
        if ($urandom_range(0, 15) == 0) v = CFG_MAX;
        return v;
    endfunction

    // Drive one word and wait for it to be taken
    task automatic send_word(logic signed [31:0] meas, logic signed [31:0] targ,
                             bit typed, logic signed [31:0] typed_force);
        int gap;
        logic signed [31:0] f;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        measured <= meas;
        target <= targ;
        do @(posedge clk); while (in_stall);
        f = next_force(meas, targ);
        force_q.push_back(typed ? typed_force : f);
        words_sent++;
    endtask

    task automatic drain();
        while (force_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Result side: random stall, then check against the oldest expectation
    initial
    begin
        int n;
        logic signed [31:0] want;
        @(posedge rst_n);
        forever
        begin
            n = idle_on ? $urandom_range(0, 13) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            words_seen++;
            if (force_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected force word %0d", force_res);
            end
            else
            begin
                want = force_q.pop_front();
                if (force_res !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch at word %0d: expected %0d, got %0d",
                                 words_seen, want, force_res);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int mode;
        logic signed [31:0] m, t, err;
        gain_range_regs = '{31'd0, 31'd65536, 31'd0, 31'd65536,
                            31'd0, 31'd65536, 31'd0, 31'd65536};
        prev_err = 0;
        integ_acc = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            // Register settings: reset values, then extremes, then a fixed set, then random
            if (ph == 1)
                load_gains(CFG_MAX, '0, CFG_MAX, '0, CFG_MAX, '0, CFG_MAX, '0);
            else if (ph == 2)
                load_gains(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX,
                           CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
            else if (ph == 3)
                load_gains(31'h0001_0000, 31'h0001_0000, 31'h0002_0000, 31'h0000_8000,
                           31'h0003_0000, 31'h0002_0000, 31'h0001_8000, 31'h0004_0000);
            else if (ph > 3)
                load_gains(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                           rand_reg(), rand_reg(), rand_reg(), rand_reg());
            idle_on = (ph % 3) != 2;

            if (ph <= 1)
                foreach (dir_rows[k])
                    send_word(dir_rows[k].meas, dir_rows[k].targ,
                              ph == 0 && dir_rows[k].typed, dir_rows[k].force_val);

            // Random part: mostly small errors that move by about the slopes
            err = 0;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                mode = $urandom_range(0, 7);
                m = $urandom;
                if (mode == 0)
                    t = $urandom;
                else if (mode <= 3)
                    t = m + ($signed($urandom) >>> $urandom_range(0, 31));
                else
                begin
                    err = err + ($signed($urandom) >>> $urandom_range(12, 31));
                    t = m + err;
                end
                send_word(m, t, 1'b0, '0);
            end
            in_valid <= 1'b0;
            drain();
        end

        $display("%0d words sent over %0d register settings, %0d force words checked",
                 words_sent, N_PHASE, words_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
